### design/lpch_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpch_pkg
// Shared types and constants of the label pair conditional histogram.
// ----------------------------------------------------------------------------
package lpch_pkg;

  localparam int unsigned LabelBits  = 6;
  localparam int unsigned Labels     = 1 << LabelBits;
  localparam int unsigned AddrBits   = 2 * LabelBits;
  localparam int unsigned CountBits  = 24;
  localparam int unsigned ProbBits   = 17;
  localparam int unsigned FracBits   = 16;
  // one spare bit: a saturated pair count plus the rounding half can carry out
  localparam int unsigned NumBits    = CountBits + FracBits + 1;
  localparam int unsigned CfgBits    = 7;
  localparam int unsigned CfgIdxBits = 2;

  localparam logic [CountBits-1:0] CountMax = '1;
  localparam logic [ProbBits-1:0]  OneQ16   = ProbBits'(1) << FracBits;

  localparam logic [CfgIdxBits-1:0] RegLowClusters  = 2'd0;
  localparam logic [CfgIdxBits-1:0] RegHighClusters = 2'd1;
  localparam logic [CfgBits-1:0]    ClustersReset   = 7'd64;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  localparam logic REQ_ACCUM = 1'b0;
  localparam logic REQ_READ  = 1'b1;

  typedef struct packed {
    logic    clr_en;
    logic    take_in;
    logic    rd_en;
    logic    wr_en;
    logic    div_start;
    logic    load_out;
    status_e kind;
  } lpch_cmd_t;

  typedef struct packed {
    logic clr_done;
    logic in_valid;
    logic in_range;
    logic is_read;
    logic row_zero;
    logic div_done;
    logic out_free;
  } lpch_stat_t;

endpackage

### design/lpch_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpch_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module lpch_div
  import lpch_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic [NumBits-1:0]   num_i,
  input  logic [CountBits-1:0] den_i,
  output logic                 done_o,
  output logic [NumBits-1:0]   quot_o
);

  localparam int unsigned CntBits = $clog2(NumBits + 1);

  logic [NumBits-1:0]   quot_q, quot_d;
  logic [CountBits:0]   rem_q, rem_d;
  logic [CountBits-1:0] den_q;
  logic [CntBits-1:0]   cnt_q, cnt_d;
  logic                 busy_q, busy_d, done_q, done_d;
  logic [CountBits:0]   shifted;
  logic [CountBits:0]   diff;

  always_comb begin
    shifted = {rem_q[CountBits-1:0], quot_q[NumBits-1]};
    diff    = shifted - {1'b0, den_q};
    quot_d  = quot_q;
    rem_d   = rem_q;
    cnt_d   = cnt_q;
    busy_d  = busy_q;
    done_d  = 1'b0;
    if (start_i) begin
      quot_d = num_i;
      rem_d  = '0;
      cnt_d  = CntBits'(NumBits);
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (!diff[CountBits]) begin
        rem_d  = diff;
        quot_d = {quot_q[NumBits-2:0], 1'b1};
      end else begin
        rem_d  = shifted;
        quot_d = {quot_q[NumBits-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CntBits'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quot_q <= quot_d;
    rem_q  <= rem_d;
    if (start_i) den_q <= den_i;
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule

### design/lpch_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpch_ctrl
// Sequencer: clearing sweep, lookup, update or divide, result handoff.
// ----------------------------------------------------------------------------
module lpch_ctrl
  import lpch_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  lpch_stat_t stat_i,
  output lpch_cmd_t  cmd_o,
  output logic       in_ready_o
);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_LOOKUP,
    S_CHECK,
    S_DIVIDE,
    S_RESULT
  } state_e;

  state_e  state_q, state_d;
  status_e kind_q, kind_d;

  always_comb begin
    state_d         = state_q;
    kind_d          = kind_q;
    cmd_o           = '0;
    cmd_o.kind      = kind_q;
    unique case (state_q)
      S_CLEAR: begin
        cmd_o.clr_en = 1'b1;
        if (stat_i.clr_done) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (stat_i.in_valid) begin
          cmd_o.take_in = 1'b1;
          state_d       = S_LOOKUP;
        end
      end
      S_LOOKUP: begin
        if (!stat_i.in_range) begin
          kind_d  = ST_RANGE;
          state_d = S_RESULT;
        end else begin
          cmd_o.rd_en = 1'b1;
          state_d     = S_CHECK;
        end
      end
      S_CHECK: begin
        priority if (!stat_i.is_read) begin
          cmd_o.wr_en = 1'b1;
          state_d     = S_IDLE;
        end else if (stat_i.row_zero) begin
          kind_d  = ST_EMPTY;
          state_d = S_RESULT;
        end else begin
          cmd_o.div_start = 1'b1;
          state_d         = S_DIVIDE;
        end
      end
      S_DIVIDE: begin
        if (stat_i.div_done) begin
          kind_d  = ST_OK;
          state_d = S_RESULT;
        end
      end
      S_RESULT: begin
        if (stat_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      kind_q  <= ST_OK;
    end else begin
      state_q <= state_d;
      kind_q  <= kind_d;
    end
  end

  assign in_ready_o = (state_q == S_IDLE);

endmodule

### design/lpch_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpch_dp
// Datapath: cluster registers, count memories, divider, output register.
// ----------------------------------------------------------------------------
module lpch_dp
  import lpch_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  lpch_cmd_t             cmd_i,
  output lpch_stat_t            stat_o,
  input  logic                  in_valid_i,
  input  logic                  req_type_i,
  input  logic [LabelBits-1:0]  low_label_i,
  input  logic [LabelBits-1:0]  high_label_i,
  input  logic                  cfg_we_i,
  input  logic [CfgIdxBits-1:0] cfg_index_i,
  input  logic [CfgBits-1:0]    cfg_data_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [ProbBits-1:0]   probability_o,
  output logic [CountBits-1:0]  pair_count_o,
  output logic [CountBits-1:0]  row_count_o,
  output status_e               status_o
);

  logic [CfgBits-1:0]   low_clu_q, high_clu_q;
  logic [LabelBits-1:0] lo_q, hi_q;
  logic                 req_q, rng_q;
  logic [AddrBits-1:0]  clr_cnt_q;

  logic [CountBits-1:0] pair_mem [Labels*Labels];
  logic [CountBits-1:0] row_mem  [Labels];
  logic [CountBits-1:0] pair_rd_q, row_rd_q;

  logic [AddrBits-1:0]  pair_waddr;
  logic [LabelBits-1:0] row_waddr;
  logic [CountBits-1:0] pair_wdata, row_wdata;
  logic                 mem_we;

  logic                 div_done;
  logic [NumBits-1:0]   quot, num;
  logic [ProbBits-1:0]  prob_cap;

  logic                 out_valid_q;
  logic [ProbBits-1:0]  prob_q;
  logic [CountBits-1:0] pair_q, row_q;
  status_e              status_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      low_clu_q  <= ClustersReset;
      high_clu_q <= ClustersReset;
    end else if (cfg_we_i) begin
      if (cfg_index_i == RegLowClusters)  low_clu_q  <= cfg_data_i;
      if (cfg_index_i == RegHighClusters) high_clu_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.take_in) begin
      lo_q  <= low_label_i;
      hi_q  <= high_label_i;
      req_q <= req_type_i;
      rng_q <= ({1'b0, low_label_i} < low_clu_q) && ({1'b0, high_label_i} < high_clu_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) clr_cnt_q <= '0;
    else if (cmd_i.clr_en) clr_cnt_q <= clr_cnt_q + 1'b1;
  end

  // counts saturate
  always_comb begin
    mem_we     = cmd_i.clr_en || cmd_i.wr_en;
    pair_waddr = cmd_i.clr_en ? clr_cnt_q : {lo_q, hi_q};
    row_waddr  = cmd_i.clr_en ? clr_cnt_q[LabelBits-1:0] : lo_q;
    pair_wdata = '0;
    row_wdata  = '0;
    if (!cmd_i.clr_en) begin
      pair_wdata = (pair_rd_q == CountMax) ? pair_rd_q : pair_rd_q + 1'b1;
      row_wdata  = (row_rd_q == CountMax) ? row_rd_q : row_rd_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      pair_mem[pair_waddr] <= pair_wdata;
      row_mem[row_waddr]   <= row_wdata;
    end
    if (cmd_i.rd_en) begin
      pair_rd_q <= pair_mem[{lo_q, hi_q}];
      row_rd_q  <= row_mem[lo_q];
    end
  end

  assign num = NumBits'({pair_rd_q, {FracBits{1'b0}}}) + NumBits'(row_rd_q >> 1);

  lpch_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.div_start),
    .num_i   (num),
    .den_i   (row_rd_q),
    .done_o  (div_done),
    .quot_o  (quot)
  );

  assign prob_cap = (quot > NumBits'(OneQ16)) ? OneQ16 : quot[ProbBits-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_valid_q <= 1'b0;
    else if (cmd_i.load_out) out_valid_q <= 1'b1;
    else if (out_ready_i) out_valid_q <= 1'b0;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      status_q <= cmd_i.kind;
      if (cmd_i.kind == ST_OK) begin
        prob_q <= prob_cap;
        pair_q <= pair_rd_q;
        row_q  <= row_rd_q;
      end else begin
        prob_q <= '0;
        pair_q <= '0;
        row_q  <= '0;
      end
    end
  end

  always_comb begin
    stat_o          = '0;
    stat_o.clr_done = (clr_cnt_q == '1);
    stat_o.in_valid = in_valid_i;
    stat_o.in_range = rng_q;
    stat_o.is_read  = (req_q == REQ_READ);
    stat_o.row_zero = (row_rd_q == '0);
    stat_o.div_done = div_done;
    stat_o.out_free = !out_valid_q || out_ready_i;
  end

  assign out_valid_o   = out_valid_q;
  assign probability_o = prob_q;
  assign pair_count_o  = pair_q;
  assign row_count_o   = row_q;
  assign status_o      = status_q;

endmodule

### design/label_pair_conditional_histogram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// label_pair_conditional_histogram
// Joint label-pair histogram with a conditional probability read.
// ----------------------------------------------------------------------------
// Slave stream: tuser = req_type (0 accumulate, 1 read); tdata carries the
// low and high labels. Master stream: tdata carries probability (Q1.16),
// pair count and row count; tuser carries status (0 ok, 1 out of range,
// 2 empty row). Config channel writes low_clusters (index 0) or
// high_clusters (index 1); it is always ready.
// One word in flight at a time. An accumulate gives no word. An
// out-of-range word goes from lookup straight to the result handoff. A
// read of a filled row makes one memory lookup, then runs the bit-serial
// divider, one quotient bit per cycle.
// Reset: after rst_ni rises, a clearing pass zeros the pair and row count
// memories; s_tready stays low until it ends.
// The result sits in an output register; while the receiver stalls, accumulates
// still run and one further result word is processed up to its handoff.
// ----------------------------------------------------------------------------
module label_pair_conditional_histogram
  import lpch_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [15:0]           s_tdata,   // [5:0] low_label, [11:6] high_label
  input  logic                  s_tuser,   // [0] req_type
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [71:0]           m_tdata,   // [16:0] probability, [40:17] pair_count,
                                           // [64:41] row_count
  output logic [1:0]            m_tuser,   // [1:0] status
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CfgIdxBits-1:0] cfg_index_i,
  input  logic [CfgBits-1:0]    cfg_data_i
);

  lpch_cmd_t            cmd;
  lpch_stat_t           stat;
  logic [ProbBits-1:0]  prob;
  logic [CountBits-1:0] pair_cnt, row_cnt;
  status_e              status;

  assign cfg_ready_o = 1'b1;

  lpch_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .stat_i     (stat),
    .cmd_o      (cmd),
    .in_ready_o (s_tready)
  );

  lpch_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .in_valid_i    (s_tvalid),
    .req_type_i    (s_tuser),
    .low_label_i   (s_tdata[5:0]),
    .high_label_i  (s_tdata[11:6]),
    .cfg_we_i      (cfg_valid_i && cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .out_valid_o   (m_tvalid),
    .out_ready_i   (m_tready),
    .probability_o (prob),
    .pair_count_o  (pair_cnt),
    .row_count_o   (row_cnt),
    .status_o      (status)
  );

  assign m_tdata = {7'b0, row_cnt, pair_cnt, prob};
  assign m_tuser = status;

  a_prob_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid && (m_tuser == ST_OK) |-> m_tdata[16:0] <= OneQ16)
    else $error("probability above 1.0");

  a_ok_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid && (m_tuser == ST_OK) |-> m_tdata[64:41] != '0)
    else $error("ok result with empty row");

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid && (m_tuser != ST_OK) |-> m_tdata == '0)
    else $error("error result carries data");

  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_tvalid && s_tready |=> !s_tready)
    else $error("second word taken while busy");

endmodule

### sim/lpch_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpch_checker
// Watches the label, result and config channels of the histogram, keeps its
// own count tables, predicts each result word and compares it field by field.
// ----------------------------------------------------------------------------
module lpch_checker
  import lpch_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_tvalid,
  input  logic                  s_tready,
  input  logic [15:0]           s_tdata,
  input  logic                  s_tuser,
  input  logic                  m_tvalid,
  input  logic                  m_tready,
  input  logic [71:0]           m_tdata,
  input  logic [1:0]            m_tuser,
  input  logic                  cfg_valid_i,
  input  logic                  cfg_ready_o,
  input  logic [CfgIdxBits-1:0] cfg_index_i,
  input  logic [CfgBits-1:0]    cfg_data_i,
  output int                    errors_o,
  output int                    pending_o,
  output int                    words_o,
  output int                    reads_o
);

  typedef struct packed {
    logic [ProbBits-1:0]  prob;
    logic [CountBits-1:0] pair;
    logic [CountBits-1:0] row;
    status_e              status;
  } lookup_t;

  logic [CountBits-1:0] pair_tab [Labels*Labels];
  logic [CountBits-1:0] row_tab  [Labels];
  logic [CfgBits-1:0]   low_lim, high_lim;
  lookup_t              lookups_q[$];

  assign pending_o = lookups_q.size();

  function automatic logic [CountBits-1:0] bump(logic [CountBits-1:0] v);
    return (v == CountMax) ? v : v + 1'b1;
  endfunction

  task automatic apply_word(logic req, logic [5:0] lo, logic [5:0] hi);
    lookup_t         r;
    int unsigned     ll, hl, idx;
    logic [63:0]     q;
    ll  = (low_lim  > Labels) ? Labels : low_lim;
    hl  = (high_lim > Labels) ? Labels : high_lim;
    idx = lo * Labels + hi;
    r   = '0;
    if (lo >= ll || hi >= hl) begin
      r.status = ST_RANGE;
      lookups_q.push_back(r);
    end else if (req == REQ_ACCUM) begin
      row_tab[lo]   = bump(row_tab[lo]);
      pair_tab[idx] = bump(pair_tab[idx]);
    end else if (row_tab[lo] == 0) begin
      r.status = ST_EMPTY;
      lookups_q.push_back(r);
    end else begin
      q = ((64'(pair_tab[idx]) << FracBits) + 64'(row_tab[lo] >> 1)) / 64'(row_tab[lo]);
      if (q > OneQ16) q = OneQ16;
      r.prob   = q[ProbBits-1:0];
      r.pair   = pair_tab[idx];
      r.row    = row_tab[lo];
      r.status = ST_OK;
      lookups_q.push_back(r);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    lookup_t e;
    if (!rst_ni) begin
      foreach (pair_tab[i]) pair_tab[i] = '0;
      foreach (row_tab[i]) row_tab[i] = '0;
      low_lim   = ClustersReset;
      high_lim  = ClustersReset;
      errors_o  = 0;
      words_o   = 0;
      reads_o   = 0;
      lookups_q.delete();
    end else begin
      if (m_tvalid && m_tready) begin
        reads_o++;
        if (lookups_q.size() == 0) begin
          $error("result word with no expectation");
          errors_o++;
        end else begin
          e = lookups_q.pop_front();
          if (m_tdata[16:0] !== e.prob) begin
            $error("probability expected %0d got %0d", e.prob, m_tdata[16:0]);
            errors_o++;
          end
          if (m_tdata[40:17] !== e.pair) begin
            $error("pair_count expected %0d got %0d", e.pair, m_tdata[40:17]);
            errors_o++;
          end
          if (m_tdata[64:41] !== e.row) begin
            $error("row_count expected %0d got %0d", e.row, m_tdata[64:41]);
            errors_o++;
          end
          if (m_tuser !== e.status) begin
            $error("status expected %0d got %0d", e.status, m_tuser);
            errors_o++;
          end
        end
      end
      if (s_tvalid && s_tready) begin
        words_o++;
        apply_word(s_tuser, s_tdata[5:0], s_tdata[11:6]);
      end
      if (cfg_valid_i && cfg_ready_o) begin
        if (cfg_index_i == RegLowClusters) low_lim = cfg_data_i;
        else if (cfg_index_i == RegHighClusters) high_lim = cfg_data_i;
      end
    end
  end

endmodule

### sim/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives label words in phases under several cluster settings, with random
// gaps on both streams; a separate checker predicts and compares results.
// ----------------------------------------------------------------------------
module testbench;
  import lpch_pkg::*;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [15:0]           s_tdata = '0;
  logic                  s_tuser = 1'b0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [71:0]           m_tdata;
  logic [1:0]            m_tuser;
  logic                  cfg_valid_i = 1'b0;
  logic                  cfg_ready_o;
  logic [CfgIdxBits-1:0] cfg_index_i = '0;
  logic [CfgBits-1:0]    cfg_data_i = '0;
  int                    errors, pending, words, reads;
  int                    idle_cycles;
  logic                  done = 1'b0;

  label_pair_conditional_histogram i_dut (.*);

  lpch_checker i_checker (
    .clk_i, .rst_ni, .s_tvalid, .s_tready, .s_tdata, .s_tuser,
    .m_tvalid, .m_tready, .m_tdata, .m_tuser,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i,
    .errors_o(errors), .pending_o(pending), .words_o(words), .reads_o(reads)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // result side stall
  initial begin
    int n;
    forever begin
      @(posedge clk_i);
      n = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 10);
      if (n > 0) begin
        m_tready <= 1'b0;
        repeat (n) @(posedge clk_i);
      end
      m_tready <= 1'b1;
      do @(posedge clk_i); while (!(m_tvalid && m_tready));
      m_tready <= 1'b0;
    end
  end

  // stall watchdog
  always @(posedge clk_i) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !rst_ni) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 20000 && !done) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  task automatic send(logic req, logic [5:0] lo, logic [5:0] hi, bit gaps);
    int n;
    n = gaps ? $urandom_range(0, 10) : 0;
    if (n > 0) begin
      s_tvalid <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= req;
    s_tdata  <= {4'b0, hi, lo};
    do @(posedge clk_i); while (!s_tready);
  endtask

  task automatic settle();
    s_tvalid <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CfgIdxBits-1:0] idx, logic [CfgBits-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
  endtask

  // mostly accumulates into a few hot rows, with reads and out-of-range words
  task automatic random_phase(int count, int lo_lim, int hi_lim);
    logic [5:0] lo, hi;
    bit         gaps;
    for (int i = 0; i < count; i++) begin
      gaps = ($urandom_range(0, 99) >= 30) || (i % 100 >= 50);
      lo = ($urandom_range(0, 9) == 0) ? 6'($urandom) : 6'($urandom_range(0, lo_lim - 1));
      hi = ($urandom_range(0, 9) == 0) ? 6'($urandom) : 6'($urandom_range(0, hi_lim - 1));
      if ($urandom_range(0, 1)) lo = lo % 4;
      send(($urandom_range(0, 3) == 0) ? REQ_READ : REQ_ACCUM, lo, hi, gaps);
    end
    settle();
  endtask

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: empty rows, corners, range edges
    send(REQ_READ, 6'd0, 6'd0, 0);
    send(REQ_READ, 6'd63, 6'd63, 0);
    send(REQ_ACCUM, 6'd0, 6'd0, 0);
    send(REQ_ACCUM, 6'd0, 6'd0, 0);
    send(REQ_ACCUM, 6'd0, 6'd63, 0);
    send(REQ_ACCUM, 6'd63, 6'd63, 0);
    send(REQ_READ, 6'd0, 6'd0, 0);
    send(REQ_READ, 6'd0, 6'd63, 0);
    send(REQ_READ, 6'd0, 6'd5, 0);
    send(REQ_READ, 6'd63, 6'd63, 0);
    send(REQ_READ, 6'd63, 6'd0, 0);
    send(REQ_ACCUM, 6'd42, 6'd21, 1);
    send(REQ_READ, 6'd42, 6'd21, 1);
    settle();
    write_reg(RegLowClusters, 7'd1);
    write_reg(RegHighClusters, 7'd1);
    send(REQ_ACCUM, 6'd1, 6'd0, 0);
    send(REQ_ACCUM, 6'd0, 6'd1, 0);
    send(REQ_READ, 6'd0, 6'd0, 0);
    send(REQ_READ, 6'd63, 6'd63, 0);
    settle();
    write_reg(RegLowClusters, 7'd0);
    write_reg(RegHighClusters, 7'd127);
    send(REQ_ACCUM, 6'd0, 6'd0, 0);
    send(REQ_READ, 6'd0, 6'd0, 0);
    settle();

    write_reg(RegLowClusters, 7'd64);
    write_reg(RegHighClusters, 7'd64);
    random_phase(450, 64, 64);
    write_reg(RegLowClusters, 7'd5);
    write_reg(RegHighClusters, 7'd3);
    random_phase(250, 5, 3);
    write_reg(RegLowClusters, 7'd127);
    write_reg(RegHighClusters, 7'd33);
    random_phase(250, 64, 33);
    write_reg(RegLowClusters, 7'd2);
    write_reg(RegHighClusters, 7'd64);
    random_phase(200, 2, 64);

    done = 1'b1;
    $display("Accepted %0d label words and checked %0d result words", words, reads);
    $display("over six cluster settings, including zero and above the table size.");
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

### files.f
design/lpch_pkg.sv
design/lpch_div.sv
design/lpch_ctrl.sv
design/lpch_dp.sv
design/label_pair_conditional_histogram.sv
sim/lpch_checker.sv
sim/testbench.sv
